// ----- rtl/cpu_arith_exec_unit_assert.svh -----
// Assertion macros for the arithmetic execution unit
`ifndef CPU_ARITH_EXEC_UNIT_ASSERT_SVH
`define CPU_ARITH_EXEC_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAEU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CAEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/caeu_pkg.sv -----
// Shared codes and controller/datapath interface types for the arithmetic execution unit
package caeu_pkg;

  localparam logic [3:0] ACT_WRITE   = 4'd0;
  localparam logic [3:0] ACT_ADC     = 4'd1;
  localparam logic [3:0] ACT_SBC     = 4'd2;
  localparam logic [3:0] ACT_INX     = 4'd3;
  localparam logic [3:0] ACT_INY     = 4'd4;
  localparam logic [3:0] ACT_DEX     = 4'd5;
  localparam logic [3:0] ACT_DEY     = 4'd6;
  localparam logic [3:0] ACT_INC_MEM = 4'd7;
  localparam logic [3:0] ACT_DEC_MEM = 4'd8;

  localparam logic [2:0] MODE_IMM   = 3'd0;
  localparam logic [2:0] MODE_ZP    = 3'd1;
  localparam logic [2:0] MODE_ZP_X  = 3'd2;
  localparam logic [2:0] MODE_ABS   = 3'd3;
  localparam logic [2:0] MODE_ABS_X = 3'd4;
  localparam logic [2:0] MODE_ABS_Y = 3'd5;
  localparam logic [2:0] MODE_IND_X = 3'd6;
  localparam logic [2:0] MODE_IND_Y = 3'd7;

  typedef enum logic [1:0] {
    RD_PTR_LO,
    RD_PTR_HI,
    RD_EA
  } rd_sel_t;

  typedef struct packed {
    logic    capture_item;
    logic    ea_direct;
    logic    ptr_lo;
    logic    ea_ptr;
    logic    use_mem;
    logic    capture_res;
    logic    we_item;
    logic    we_rmw;
    rd_sel_t rd_sel;
    logic    load_out;
  } caeu_cmd_t;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] mode;
  } caeu_status_t;

endpackage

// ----- rtl/cpu_arith_exec_unit.sv -----
// Top level of the 6502-style arithmetic execution unit with local byte memory
//
// Input stream: one transfer per instruction; in_tuser carries the action code,
// in_tdata the mode, operand, A, X, Y, carry and write byte. Codes above 8 are
// dropped without a result. Output stream: one transfer per valid action with
// the new value and the N, Z, C, V flags plus the C/V-written marker.
// Items are handled one at a time; in_tready is high only while idle.
// Accept-to-accept time is set by the memory's single read port with a
// registered read: writes, register ops and immediate mode need no read,
// direct memory modes read the operand, and indexed-indirect/indirect-indexed
// modes read two pointer bytes before the operand read. A result waits in an
// output register, so the next item is accepted and worked on while the
// receiver stalls; a second result then holds until the first transfer
// completes.
// Reset clears the sequencer and the output valid; memory contents are not
// cleared and must be written before they are read.
module cpu_arith_exec_unit
  import caeu_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] mode, [18:3] operand, [26:19] acc_in, [34:27] x_in, [42:35] y_in,
  // [43] carry_in, [51:44] write_data, [55:52] zero
  input  logic [55:0] in_tdata,
  // [3:0] action
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] value, [8] negative, [9] zero, [10] carry, [11] overflow,
  // [12] cv_written, [15:13] zero
  output logic [15:0] out_tdata
);

  caeu_cmd_t    cmd;
  caeu_status_t status;
  logic [7:0]   value;
  logic         negative, zero, carry, overflow, cv_written;

  caeu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  caeu_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .action     (in_tuser),
    .mode       (in_tdata[2:0]),
    .operand    (in_tdata[18:3]),
    .acc_in     (in_tdata[26:19]),
    .x_in       (in_tdata[34:27]),
    .y_in       (in_tdata[42:35]),
    .carry_in   (in_tdata[43]),
    .write_data (in_tdata[51:44]),
    .value      (value),
    .negative   (negative),
    .zero       (zero),
    .carry      (carry),
    .overflow   (overflow),
    .cv_written (cv_written)
  );

  assign out_tdata = {3'b000, cv_written, overflow, carry, zero, negative, value};

endmodule

// ----- rtl/caeu_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module caeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/caeu_ctrl.sv -----
// Sequencing state machine for the arithmetic execution unit
`include "cpu_arith_exec_unit_assert.svh"
module caeu_ctrl
  import caeu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  caeu_status_t status,
  output caeu_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PTR_EA,
    ST_RD,
    ST_OPND,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_alu_mem, is_rmw, uses_mem;

  assign is_alu_mem = (status.action == ACT_ADC) || (status.action == ACT_SBC);
  assign is_rmw     = (status.action == ACT_INC_MEM) || (status.action == ACT_DEC_MEM);
  assign uses_mem   = (is_alu_mem || is_rmw) && (status.mode != MODE_IMM);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd              = '0;
    cmd.rd_sel       = RD_EA;
    cmd.capture_item = in_tvalid && in_tready;
    state_nxt        = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.action > ACT_DEC_MEM) begin
          state_nxt = ST_IDLE;
        end else if (uses_mem) begin
          if (status.mode == MODE_IND_X || status.mode == MODE_IND_Y) begin
            state_nxt = ST_PTR_LO;
          end else begin
            cmd.ea_direct = 1'b1;
            state_nxt     = ST_RD;
          end
        end else begin
          cmd.capture_res = 1'b1;
          cmd.we_item     = (status.action == ACT_WRITE);
          state_nxt       = ST_FIN;
        end
      end
      ST_PTR_LO: begin
        cmd.rd_sel = RD_PTR_LO;
        state_nxt  = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        cmd.rd_sel = RD_PTR_HI;
        cmd.ptr_lo = 1'b1;
        state_nxt  = ST_PTR_EA;
      end
      ST_PTR_EA: begin
        cmd.ea_ptr = 1'b1;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_OPND;
      end
      ST_OPND: begin
        cmd.use_mem     = 1'b1;
        cmd.capture_res = 1'b1;
        cmd.we_rmw      = is_rmw;
        state_nxt       = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CAEU_ASSERT_NEXT(a_accept_dispatch, in_tvalid && in_tready, state_r == ST_DISPATCH, "accept did not lead to dispatch")
  `CAEU_ASSERT_IMPL(a_no_we_on_accept, cmd.we_item || cmd.we_rmw, !(in_tvalid && in_tready), "memory write during accept")
  `CAEU_ASSERT_IMPL(a_rmw_action, cmd.we_rmw, status.action == ACT_INC_MEM || status.action == ACT_DEC_MEM, "write-back for non-rmw action")
  `CAEU_ASSERT_NEXT(a_fin_holds, state_r == ST_FIN && out_valid_r && !out_tready, state_r == ST_FIN && out_valid_r, "pending result lost")

endmodule

// ----- rtl/caeu_dp.sv -----
// Datapath: item registers, address generation, byte memory, ALU and output register
module caeu_dp
  import caeu_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic         clk,
  input  caeu_cmd_t    cmd,
  output caeu_status_t status,
  input  logic [3:0]   action,
  input  logic [2:0]   mode,
  input  logic [15:0]  operand,
  input  logic [7:0]   acc_in,
  input  logic [7:0]   x_in,
  input  logic [7:0]   y_in,
  input  logic         carry_in,
  input  logic [7:0]   write_data,
  output logic [7:0]   value,
  output logic         negative,
  output logic         zero,
  output logic         carry,
  output logic         overflow,
  output logic         cv_written
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [3:0]  action_r;
  logic [2:0]  mode_r;
  logic [15:0] opd_r;
  logic [7:0]  acc_r, x_r, y_r, wd_r;
  logic        c_r;
  logic [7:0]  ptr_lo_r;
  logic [15:0] ea_r;
  logic [7:0]  val_r;
  logic        n_r, z_r, cf_r, v_r, cvw_r;
  logic [7:0]  out_val_r;
  logic        out_n_r, out_z_r, out_c_r, out_v_r, out_cvw_r;

  logic [7:0]           rdata, zp_idx, ptr_base, ptr_addr;
  logic [15:0]          ea_direct, ea_ptr;
  logic [ADDR_BITS-1:0] raddr, waddr;
  logic [7:0]           wdata;
  logic                 we;

  logic [7:0] m, b, alu_val;
  logic [8:0] sum9;
  logic       alu_flags, alu_c, alu_v, alu_cvw;

  assign status.action = action_r;
  assign status.mode   = mode_r;

  assign zp_idx   = opd_r[7:0] + x_r;
  assign ptr_base = (mode_r == MODE_IND_X) ? zp_idx : opd_r[7:0];
  assign ptr_addr = (cmd.rd_sel == RD_PTR_HI) ? ptr_base + 8'd1 : ptr_base;
  assign ea_ptr   = {rdata, ptr_lo_r} + ((mode_r == MODE_IND_Y) ? {8'd0, y_r} : 16'd0);

  always_comb begin
    unique case (mode_r)
      MODE_ZP:    ea_direct = {8'd0, opd_r[7:0]};
      MODE_ZP_X:  ea_direct = {8'd0, zp_idx};
      MODE_ABS:   ea_direct = opd_r;
      MODE_ABS_X: ea_direct = opd_r + {8'd0, x_r};
      MODE_ABS_Y: ea_direct = opd_r + {8'd0, y_r};
      default:    ea_direct = opd_r;
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR_LO, RD_PTR_HI: raddr = {{(ADDR_BITS-8){1'b0}}, ptr_addr};
      default:              raddr = ea_r[ADDR_BITS-1:0];
    endcase
  end

  assign m    = cmd.use_mem ? rdata : opd_r[7:0];
  assign b    = (action_r == ACT_SBC) ? ~m : m;
  assign sum9 = {1'b0, acc_r} + {1'b0, b} + {8'd0, c_r};

  always_comb begin
    alu_val   = 8'd0;
    alu_flags = 1'b1;
    alu_c     = c_r;
    alu_v     = 1'b0;
    alu_cvw   = 1'b0;
    unique case (action_r)
      ACT_WRITE: begin
        alu_val   = wd_r;
        alu_flags = 1'b0;
      end
      ACT_ADC, ACT_SBC: begin
        alu_val = sum9[7:0];
        alu_c   = sum9[8];
        alu_v   = (acc_r[7] ^ sum9[7]) & (b[7] ^ sum9[7]);
        alu_cvw = 1'b1;
      end
      ACT_INX:     alu_val = x_r + 8'd1;
      ACT_INY:     alu_val = y_r + 8'd1;
      ACT_DEX:     alu_val = x_r - 8'd1;
      ACT_DEY:     alu_val = y_r - 8'd1;
      ACT_INC_MEM: alu_val = m + 8'd1;
      ACT_DEC_MEM: alu_val = m - 8'd1;
      default:     alu_val = 8'd0;
    endcase
  end

  assign we    = cmd.we_item || cmd.we_rmw;
  assign waddr = cmd.we_item ? opd_r[ADDR_BITS-1:0] : ea_r[ADDR_BITS-1:0];
  assign wdata = cmd.we_item ? wd_r : alu_val;

  caeu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture_item) begin
      action_r <= action;
      mode_r   <= mode;
      opd_r    <= operand;
      acc_r    <= acc_in;
      x_r      <= x_in;
      y_r      <= y_in;
      c_r      <= carry_in;
      wd_r     <= write_data;
    end
    if (cmd.ptr_lo) begin
      ptr_lo_r <= rdata;
    end
    if (cmd.ea_direct) begin
      ea_r <= ea_direct;
    end else if (cmd.ea_ptr) begin
      ea_r <= ea_ptr;
    end
    if (cmd.capture_res) begin
      val_r <= alu_val;
      n_r   <= alu_flags & alu_val[7];
      z_r   <= alu_flags & (alu_val == 8'd0);
      cf_r  <= alu_c;
      v_r   <= alu_v;
      cvw_r <= alu_cvw;
    end
    if (cmd.load_out) begin
      out_val_r <= val_r;
      out_n_r   <= n_r;
      out_z_r   <= z_r;
      out_c_r   <= cf_r;
      out_v_r   <= v_r;
      out_cvw_r <= cvw_r;
    end
  end

  assign value      = out_val_r;
  assign negative   = out_n_r;
  assign zero       = out_z_r;
  assign carry      = out_c_r;
  assign overflow   = out_v_r;
  assign cv_written = out_cvw_r;

endmodule

// ----- dv/cpu_arith_exec_unit_tb.sv -----
// Self-checking stream testbench for the 6502-style arithmetic execution unit
module cpu_arith_exec_unit_tb
  import caeu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MEM_ADDR_BITS = 16;
  localparam logic [3:0] ACT_CODE_MAX  = 4'd15;
  localparam int         RANDOM_OPS    = 1000;
  localparam int         HOLD_AT       = 500;
  localparam int         HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  mode;
    logic [15:0] operand;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        carry;
    logic [7:0]  wdata;
  } instr_t;

  typedef struct packed {
    logic [7:0] value;
    logic       neg;
    logic       zero;
    logic       carry;
    logic       ovf;
    logic       cv_wr;
  } alu_result_t;

  typedef struct packed {
    instr_t      op;
    logic        typed;
    alu_result_t want;
  } plan_row_t;

  localparam alu_result_t NO_CHK = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic [7:0]  mem_img [0:65535];
  bit          mem_valid [0:65535];
  logic [15:0] recent_addr [$];
  alu_result_t expected_q [$];

  int n_sent, n_results, n_fill, n_dropped, n_errors, n_hold;

  // rows marked typed carry a hand-computed result; the rest use the predictor
  plan_row_t plan [28] = '{
    '{'{ACT_WRITE,   MODE_IMM,   16'h0010, 8'h00, 8'h00, 8'h00, 1'b1, 8'h80}, 1'b1,
      '{8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_ZP,    16'h0011, 8'h00, 8'h00, 8'h00, 1'b0, 8'h12}, 1'b1,
      '{8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_IND_Y, 16'h1280, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h7F}, 1'b1,
      '{8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_ABS,   16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF}, 1'b1,
      '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_IMM,   16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 8'h01}, 1'b1,
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_IMM,   16'h00FF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h34}, 1'b1,
      '{8'h34, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_WRITE,   MODE_IMM,   16'h0134, 8'h00, 8'h00, 8'h00, 1'b0, 8'h55}, 1'b1,
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_ADC,     MODE_IMM,   16'h0001, 8'h7F, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
      '{8'h80, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{ACT_ADC,     MODE_IMM,   16'h0001, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{ACT_SBC,     MODE_IMM,   16'h0001, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00}, 1'b1,
      '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{ACT_SBC,     MODE_IMM,   16'h0001, 8'h80, 8'h00, 8'h00, 1'b1, 8'h00}, 1'b1,
      '{8'h7F, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{'{ACT_ADC,     MODE_ZP_X,  16'h00F1, 8'h80, 8'h1F, 8'h00, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_SBC,     MODE_ABS,   16'h1280, 8'h10, 8'h00, 8'h00, 1'b1, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_ADC,     MODE_ABS_X, 16'hFFF0, 8'h01, 8'h0F, 8'h00, 1'b1, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_SBC,     MODE_ABS_Y, 16'hFFFF, 8'h40, 8'h00, 8'h01, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_ADC,     MODE_IND_X, 16'h00F0, 8'h33, 8'h20, 8'h00, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_SBC,     MODE_IND_Y, 16'h00FF, 8'hC0, 8'h00, 8'h00, 1'b1, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_INX,     MODE_IMM,   16'hFFFF, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_INY,     MODE_ABS,   16'h0000, 8'h00, 8'h00, 8'h7F, 1'b0, 8'h00}, 1'b1,
      '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_DEX,     MODE_IND_X, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
      '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_DEY,     MODE_IMM,   16'h0000, 8'h00, 8'h00, 8'h01, 1'b0, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_INC_MEM, MODE_IMM,   16'h00FF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_DEC_MEM, MODE_IMM,   16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
      '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_INC_MEM, MODE_ZP,    16'hAB10, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_DEC_MEM, MODE_ABS_Y, 16'hFFF0, 8'h00, 8'h00, 8'h0F, 1'b1, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_INC_MEM, MODE_IND_X, 16'h00FF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_DEC_MEM, MODE_IND_Y, 16'h00FF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, 1'b0, NO_CHK},
    '{'{ACT_CODE_MAX, MODE_ABS,  16'h1280, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF}, 1'b0, NO_CHK}
  };

  cpu_arith_exec_unit #(.ADDR_BITS(MEM_ADDR_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // timeout
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int draw_gap(int n);
    return ((n / 150) % 4 == 3) ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic bit reads_mem(instr_t it);
    return (it.action == ACT_ADC || it.action == ACT_SBC || it.action == ACT_INC_MEM ||
            it.action == ACT_DEC_MEM) && it.mode != MODE_IMM;
  endfunction

  // page-zero location of the low pointer byte for the indirect modes
  function automatic logic [7:0] ptr_base(instr_t it);
    logic [7:0] p;
    p = it.operand[7:0];
    if (it.mode == MODE_IND_X) p = p + it.x;
    return p;
  endfunction

  function automatic logic [15:0] operand_addr(instr_t it);
    logic [7:0]  p;
    logic [7:0]  p_hi;
    logic [15:0] ea;
    p = ptr_base(it);
    p_hi = p + 8'd1;
    case (it.mode)
      MODE_ZP:    ea = {8'h00, it.operand[7:0]};
      MODE_ZP_X:  ea = {8'h00, it.operand[7:0] + it.x};
      MODE_ABS_X: ea = it.operand + {8'h00, it.x};
      MODE_ABS_Y: ea = it.operand + {8'h00, it.y};
      MODE_IND_X: ea = {mem_img[p_hi], mem_img[p]};
      MODE_IND_Y: ea = {mem_img[p_hi], mem_img[p]} + {8'h00, it.y};
      default:    ea = it.operand;
    endcase
    return ea;
  endfunction

  // executes one instruction on the memory image; returns 0 when no result follows
  function automatic bit exec_instr(input instr_t it, output alu_result_t r);
    logic [15:0] ea;
    logic [7:0]  m, b, res, delta;
    logic [8:0]  sum;
    bit          flags;
    r = '0;
    r.carry = it.carry;
    flags = 1'b1;
    case (it.action)
      ACT_WRITE: begin
        mem_img[it.operand] = it.wdata;
        mem_valid[it.operand] = 1'b1;
        res = it.wdata;
        flags = 1'b0;
      end
      ACT_ADC, ACT_SBC: begin
        m = (it.mode == MODE_IMM) ? it.operand[7:0] : mem_img[operand_addr(it)];
        b = (it.action == ACT_SBC) ? ~m : m;
        sum = {1'b0, it.acc} + {1'b0, b} + {8'h00, it.carry};
        res = sum[7:0];
        r.carry = sum[8];
        r.ovf = ((it.acc ^ res) & (b ^ res) & 8'h80) != 8'h00;
        r.cv_wr = 1'b1;
      end
      ACT_INX: res = it.x + 8'd1;
      ACT_INY: res = it.y + 8'd1;
      ACT_DEX: res = it.x - 8'd1;
      ACT_DEY: res = it.y - 8'd1;
      ACT_INC_MEM, ACT_DEC_MEM: begin
        delta = (it.action == ACT_INC_MEM) ? 8'h01 : 8'hFF;
        if (it.mode == MODE_IMM) begin
          res = it.operand[7:0] + delta;
        end else begin
          ea = operand_addr(it);
          res = mem_img[ea] + delta;
          mem_img[ea] = res;
        end
      end
      default: return 1'b0;
    endcase
    r.value = res;
    r.neg = flags && res[7];
    r.zero = flags && res == 8'h00;
    return 1'b1;
  endfunction

  task automatic send_instr(input instr_t it, input logic typed, input alu_result_t want);
    alu_result_t r;
    int gap;
    if (exec_instr(it, r)) expected_q.push_back(typed ? want : r);
    else n_dropped++;
    if (it.action == ACT_WRITE) begin
      recent_addr.push_back(it.operand);
      if (recent_addr.size() > 32) void'(recent_addr.pop_front());
    end
    gap = draw_gap(n_sent);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {4'h0, it.wdata, it.carry, it.y, it.x, it.acc, it.operand, it.mode};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic store_byte(input logic [15:0] addr);
    instr_t w;
    w.action  = ACT_WRITE;
    w.mode    = 3'($urandom);
    w.operand = addr;
    w.acc     = 8'($urandom);
    w.x       = 8'($urandom);
    w.y       = 8'($urandom);
    w.carry   = 1'($urandom);
    w.wdata   = 8'($urandom);
    n_fill++;
    send_instr(w, 1'b0, NO_CHK);
  endtask

  // fills pointer bytes and the operand byte first where they were never stored
  task automatic issue(input instr_t it, input logic typed, input alu_result_t want);
    logic [7:0]  p;
    logic [15:0] ea;
    if (reads_mem(it)) begin
      if (it.mode == MODE_IND_X || it.mode == MODE_IND_Y) begin
        for (int k = 0; k < 2; k++) begin
          p = 8'(ptr_base(it) + k);
          if (!mem_valid[{8'h00, p}]) store_byte({8'h00, p});
        end
      end
      ea = operand_addr(it);
      if (!mem_valid[ea]) store_byte(ea);
    end
    send_instr(it, typed, want);
  endtask

  function automatic instr_t random_instr();
    instr_t it;
    int pick, r;
    it.mode    = 3'($urandom);
    it.operand = 16'($urandom);
    it.acc     = 8'($urandom);
    it.x       = 8'($urandom);
    it.y       = 8'($urandom);
    it.carry   = 1'($urandom);
    it.wdata   = 8'($urandom);
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    if (pick < 18) it.action = ACT_WRITE;
    else if (pick < 40) it.action = ACT_ADC;
    else if (pick < 60) it.action = ACT_SBC;
    else if (pick < 70) it.action = ACT_INX + 4'($urandom_range(0, 3));
    else if (pick < 94) it.action = $urandom_range(0, 1) ? ACT_INC_MEM : ACT_DEC_MEM;
    else it.action = 4'($urandom_range(ACT_DEC_MEM + 1, ACT_CODE_MAX));
    if (r < 4 && recent_addr.size() > 0)
      it.operand = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
    else if (r < 7 && it.action == ACT_WRITE)
      it.operand[15:8] = 8'h00;
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int idx, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("result %0d %s got %02h want %02h", idx, name, got, want));
  endtask

  // result side
  initial begin
    alu_result_t got, want;
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_gap(n_results);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) begin
          @(posedge clk);
          if (gap == HOLD_CYCLES) n_hold++;
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.value = out_tdata[7:0];
      got.neg   = out_tdata[8];
      got.zero  = out_tdata[9];
      got.carry = out_tdata[10];
      got.ovf   = out_tdata[11];
      got.cv_wr = out_tdata[12];
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
      end else begin
        want = expected_q.pop_front();
        check_field("value", n_results, got.value, want.value);
        check_field("negative", n_results, 8'(got.neg), 8'(want.neg));
        check_field("zero", n_results, 8'(got.zero), 8'(want.zero));
        check_field("carry", n_results, 8'(got.carry), 8'(want.carry));
        check_field("overflow", n_results, 8'(got.ovf), 8'(want.ovf));
        check_field("cv_written", n_results, 8'(got.cv_wr), 8'(want.cv_wr));
      end
      n_results++;
    end
  end

  // instruction side and end of run
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) issue(plan[i].op, plan[i].typed, plan[i].want);
    for (int i = 0; i < RANDOM_OPS; i++) issue(random_instr(), 1'b0, NO_CHK);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d transfers (%0d operand fills, %0d undefined codes), checked %0d results",
             n_sent, n_fill, n_dropped, n_results);
    $display("All actions and addressing modes with random gaps; one %0d-cycle output hold",
             n_hold);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
